@@ rtl/core/ssh_banner_recognizer_unit_assert.svh @@
// Assertion helpers shared by the recognizer RTL.
`ifndef SSH_BANNER_RECOGNIZER_UNIT_ASSERT_SVH
`define SSH_BANNER_RECOGNIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sbr_pkg.sv @@
package sbr_pkg;

    // Longest software version text that is reported.
    localparam int MAX_LINE = 255;
    // Line position counter saturates here.
    localparam int POS_LIMIT = MAX_LINE + 8;
    localparam int POS_W = $clog2(POS_LIMIT + 1);
    localparam int SLEN_W = 8;

    localparam int HDR_LEN = 7;
    localparam int SW_OFFSET = 8;

    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_2     = 8'h32;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    localparam int VER_W = 2;
    localparam logic [VER_W-1:0] VER_UNKNOWN = 2'd0;
    localparam logic [VER_W-1:0] VER_ONE     = 2'd1;
    localparam logic [VER_W-1:0] VER_TWO     = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_PENDING  = 2'd0,
        VERDICT_ACCEPTED = 2'd1,
        VERDICT_NOT_SSH  = 2'd2,
        VERDICT_IGNORED  = 2'd3
    } verdict_t;

    // Result item, packed from the lowest bit up: verdict, session_version,
    // old_version_alert, server_version_length, server_identified, both_done.
    typedef struct packed {
        logic                 pad;
        logic                 both_done;
        logic                 server_identified;
        logic [SLEN_W-1:0]    server_version_length;
        logic                 old_version_alert;
        logic [VER_W-1:0]     session_version;
        verdict_t             verdict;
    } result_t;

    // Checks one byte of the fixed "SSH-M.m" opening at the given offset.
    function automatic logic header_ok(input logic [2:0] pos, input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        unique case (pos)
            3'd0:    ok = (b == CHAR_S);
            3'd1:    ok = (b == CHAR_S);
            3'd2:    ok = (b == CHAR_H);
            3'd3:    ok = (b == CHAR_DASH);
            3'd4:    ok = (b == CHAR_1) || (b == CHAR_2);
            3'd5:    ok = (b == CHAR_DOT);
            default: ok = (b >= CHAR_0) && (b <= CHAR_9);
        endcase
        return ok;
    endfunction

endpackage

@@ rtl/core/ssh_banner_recognizer_unit.sv @@
// Recognizes the SSH identification lines of one TCP session. Each input item
// is one payload byte tagged with its direction; the block keeps a small set
// of state registers per direction (line position, first space, major and
// minor version flags, banner accepted) plus the combined session version and
// a reject flag. Every accepted byte yields exactly one result item. One byte
// is taken per clock cycle while the output is not stalled: the per-direction
// state update is a single short step, and the result is written to an output
// register in the cycle after the byte is accepted, so s_tready stays high
// whenever that register is empty or is being drained in the same cycle. Setting
// the session-clear flag in s_tuser on a byte clears all session state before
// that byte is processed.
`include "ssh_banner_recognizer_unit_assert.svh"

module ssh_banner_recognizer_unit
    import sbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] from_server, [1] session clear

    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] verdict, [3:2] session_version, [4] old_version_alert,
    // [12:5] server_version_length, [13] server_identified, [14] both_done, [15] zero
    output logic [15:0] m_tdata
);

    logic [POS_W-1:0] line_pos_reg    [2];
    logic [POS_W-1:0] line_pos_next   [2];
    logic [POS_W-1:0] space_pos_reg   [2];
    logic [POS_W-1:0] space_pos_next  [2];
    logic [1:0]       passed_reg, passed_next;
    logic [1:0]       space_seen_reg, space_seen_next;
    logic [1:0]       major_one_reg, major_one_next;
    logic [1:0]       minor_nine_reg, minor_nine_next;
    logic [VER_W-1:0] version_reg, version_next;
    logic             rejected_reg, rejected_next;

    logic             out_valid_reg;
    result_t          result_reg, result_next;

    logic             s_fire;
    logic [7:0]       data_byte;
    logic             dir;
    logic             sess_clear;

    assign data_byte  = s_tdata;
    assign dir        = s_tuser[0];
    assign sess_clear = s_tuser[1];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    always_comb begin
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] endp;
        logic [POS_W-1:0] diff;
        logic [VER_W-1:0] line_ver;
        logic             is_eol;

        // Start from the current state, or from a cleared one on a new session.
        for (int i = 0; i < 2; i++) begin
            line_pos_next[i]  = sess_clear ? '0 : line_pos_reg[i];
            space_pos_next[i] = sess_clear ? '0 : space_pos_reg[i];
        end
        passed_next     = sess_clear ? '0 : passed_reg;
        space_seen_next = sess_clear ? '0 : space_seen_reg;
        major_one_next  = sess_clear ? '0 : major_one_reg;
        minor_nine_next = sess_clear ? '0 : minor_nine_reg;
        version_next    = sess_clear ? VER_UNKNOWN : version_reg;
        rejected_next   = sess_clear ? 1'b0 : rejected_reg;

        result_next = '0;
        result_next.verdict = VERDICT_PENDING;

        pos      = line_pos_next[dir];
        endp     = '0;
        diff     = '0;
        line_ver = VER_TWO;
        is_eol   = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);

        if (rejected_next || passed_next[dir] || (&passed_next)) begin
            result_next.verdict = VERDICT_IGNORED;
        end else if (pos < POS_W'(HDR_LEN)) begin
            if (!header_ok(pos[2:0], data_byte)) begin
                rejected_next = 1'b1;
                result_next.verdict = VERDICT_NOT_SSH;
            end else begin
                if (pos == POS_W'(4)) begin
                    major_one_next[dir] = (data_byte == CHAR_1);
                end
                if (pos == POS_W'(6)) begin
                    minor_nine_next[dir] = (data_byte == CHAR_9);
                end
                line_pos_next[dir] = pos + 1'b1;
            end
        end else begin
            // The second minor digit must also be '9' for "1.99".
            if (pos == POS_W'(HDR_LEN) && data_byte != CHAR_9) begin
                minor_nine_next[dir] = 1'b0;
            end
            if (is_eol) begin
                if (major_one_next[dir] && !minor_nine_next[dir]) begin
                    line_ver = VER_ONE;
                end
                if (version_next != VER_ONE) begin
                    version_next = line_ver;
                end
                passed_next[dir] = 1'b1;
                result_next.verdict = VERDICT_ACCEPTED;
                result_next.old_version_alert = (version_next < VER_TWO);
                if (dir) begin
                    endp = space_seen_next[dir] ? space_pos_next[dir] : pos;
                    diff = (endp > POS_W'(SW_OFFSET)) ? endp - POS_W'(SW_OFFSET) : '0;
                    if (diff > POS_W'(MAX_LINE)) begin
                        diff = POS_W'(MAX_LINE);
                    end
                    result_next.server_version_length = diff[SLEN_W-1:0];
                end
            end else if (data_byte == CHAR_SPACE && !space_seen_next[dir]) begin
                space_seen_next[dir] = 1'b1;
                space_pos_next[dir]  = pos;
            end else if (data_byte < CHAR_SPACE || data_byte > CHAR_TILDE) begin
                rejected_next = 1'b1;
                result_next.verdict = VERDICT_NOT_SSH;
            end
            if (result_next.verdict == VERDICT_PENDING && pos < POS_W'(POS_LIMIT)) begin
                line_pos_next[dir] = pos + 1'b1;
            end
        end

        result_next.session_version   = version_next;
        result_next.server_identified = passed_next[1];
        result_next.both_done         = &passed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                line_pos_reg[i]  <= '0;
                space_pos_reg[i] <= '0;
            end
            passed_reg     <= '0;
            space_seen_reg <= '0;
            major_one_reg  <= '0;
            minor_nine_reg <= '0;
            version_reg    <= VER_UNKNOWN;
            rejected_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                for (int i = 0; i < 2; i++) begin
                    line_pos_reg[i]  <= line_pos_next[i];
                    space_pos_reg[i] <= space_pos_next[i];
                end
                passed_reg     <= passed_next;
                space_seen_reg <= space_seen_next;
                major_one_reg  <= major_one_next;
                minor_nine_reg <= minor_nine_next;
                version_reg    <= version_next;
                rejected_reg   <= rejected_next;
            end
            if (s_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
        end
    end

    // Once a session is rejected, every further byte of it is ignored.
    `SBR_ASSERT_NEXT(a_reject_sticky, aclk, aresetn,
        s_fire && rejected_reg && !sess_clear,
        result_reg.verdict == VERDICT_IGNORED, "byte after reject not ignored")

    // A software version length is only reported with a server acceptance.
    `SBR_ASSERT_NOW(a_slen_on_accept, aclk, aresetn,
        out_valid_reg && result_reg.server_version_length != '0,
        result_reg.verdict == VERDICT_ACCEPTED && result_reg.server_identified,
        "version length outside server acceptance")

    // Both banners done implies the server banner was accepted.
    `SBR_ASSERT_NOW(a_both_has_server, aclk, aresetn,
        out_valid_reg && result_reg.both_done,
        result_reg.server_identified, "both_done without server banner")

    // The alert only accompanies an acceptance that leaves version 1.
    `SBR_ASSERT_NOW(a_alert_version, aclk, aresetn,
        out_valid_reg && result_reg.old_version_alert,
        result_reg.verdict == VERDICT_ACCEPTED && result_reg.session_version == VER_ONE,
        "alert without version one acceptance")

endmodule
